[rtl/lobm_pkg.sv]
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared types, sizes and codes of the limit order book matcher.
// ----------------------------------------------------------------------------
package lobm_pkg;

	localparam int ORDER_SLOTS = 256;
	localparam int SLOT_W      = $clog2(ORDER_SLOTS);
	localparam int STOCK_COUNT = 5;
	localparam int SIDX_W      = (STOCK_COUNT > 1) ? $clog2(STOCK_COUNT) : 1;

	localparam int ID_W    = 20;
	localparam int STOCK_W = 3;
	localparam int QTY_W   = 16;
	localparam int PRICE_W = 20;
	localparam int VALUE_W = 20;

	typedef enum logic [1:0] {
		FUNC_BUY    = 2'd0,
		FUNC_SELL   = 2'd1,
		FUNC_CANCEL = 2'd2,
		FUNC_QUERY  = 2'd3
	} func_t;

	typedef struct packed {
		logic               is_sell;
		logic [STOCK_W-1:0] stock;
		logic [ID_W-1:0]    id;
		logic [QTY_W-1:0]   qty;
		logic [PRICE_W-1:0] price;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic load;
		logic scan_start;
		logic scan_run;
		logic fill;
		logic rest;
	} cmd_t;

	typedef struct packed {
		logic need_scan;
		logic is_cancel;
		logic scan_done;
		logic found;
		logic fill_ends;
	} sts_t;

endpackage

[rtl/lobm_ram.sv]
// ----------------------------------------------------------------------------
// lobm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lobm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/lobm_ctrl.sv]
// ----------------------------------------------------------------------------
// lobm_ctrl
// Sequencer: scans the order table, applies fills, rests remainders and
// issues one result strobe per item.
// ----------------------------------------------------------------------------
module lobm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  lobm_pkg::sts_t sts,
	output lobm_pkg::cmd_t cmd,
	output logic          busy,
	output logic          result_valid
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_FILL,
		ST_REST,
		ST_FINISH
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (sts.need_scan) begin
						cmd.scan_start = 1'b1;
						state_d = ST_SCAN;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan_run = 1'b1;
				if (sts.scan_done) begin
					state_d = sts.is_cancel ? ST_FINISH : ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				state_d = sts.found ? ST_FILL : ST_REST;
			end
			ST_FILL: begin
				cmd.fill = 1'b1;
				if (sts.fill_ends) begin
					state_d = ST_FINISH;
				end else begin
					cmd.scan_start = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_REST: begin
				cmd.rest = 1'b1;
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			busy         <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			state_q      <= state_d;
			busy         <= (state_d != ST_IDLE);
			result_valid <= (state_d == ST_FINISH);
		end
	end

endmodule

[rtl/lobm_dp.sv]
// ----------------------------------------------------------------------------
// lobm_dp
// Datapath: order table, valid bits, scan compare, fill arithmetic and the
// per-stock trade price tracking.
// ----------------------------------------------------------------------------
module lobm_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lobm_pkg::cmd_t                 cmd,
	output lobm_pkg::sts_t                 sts,
	input  logic [1:0]                    func,
	input  logic [lobm_pkg::ID_W-1:0]     order_id,
	input  logic [lobm_pkg::STOCK_W-1:0]  stock,
	input  logic [lobm_pkg::QTY_W-1:0]    quantity,
	input  logic [lobm_pkg::PRICE_W-1:0]  limit_price,
	output logic [lobm_pkg::VALUE_W-1:0]  value,
	output logic                          table_full
);

	localparam int SLOTS = lobm_pkg::ORDER_SLOTS;
	localparam int SW    = lobm_pkg::SLOT_W;

	lobm_pkg::func_t                 func_q;
	logic [lobm_pkg::ID_W-1:0]       id_q;
	logic [lobm_pkg::STOCK_W-1:0]    stock_q;
	logic [lobm_pkg::QTY_W-1:0]      qty_q;
	logic [lobm_pkg::PRICE_W-1:0]    limit_q;
	logic                            stock_ok_q;
	logic                            full_q;

	logic [SLOTS-1:0]                valid_q;
	logic [SW:0]                     cnt_q;
	logic                            rd_s1;
	logic [SW-1:0]                   slot_s1;

	logic                            found_q;
	logic [SW-1:0]                   best_slot_q;
	lobm_pkg::entry_t                best_q;
	logic                            free_found_q;
	logic [SW-1:0]                   free_slot_q;

	logic [lobm_pkg::PRICE_W-1:0]    low_q  [lobm_pkg::STOCK_COUNT];
	logic [lobm_pkg::PRICE_W-1:0]    gain_q [lobm_pkg::STOCK_COUNT];

	lobm_pkg::entry_t                rd_entry;
	logic [lobm_pkg::ENTRY_W-1:0]    rdata;
	logic                            we;
	logic [SW-1:0]                   waddr;
	lobm_pkg::entry_t                wentry;

	logic                            is_sell;
	logic                            in_stock_ok;
	logic                            issue;
	logic                            cur_valid;
	logic                            qualifies;
	logic                            better;
	logic [lobm_pkg::QTY_W-1:0]      fill_qty;
	logic [lobm_pkg::SIDX_W-1:0]     sidx;
	logic [lobm_pkg::PRICE_W-1:0]    low_cur;
	logic [lobm_pkg::PRICE_W-1:0]    gain_new;

	assign is_sell     = (func_q == lobm_pkg::FUNC_SELL);
	assign in_stock_ok = (stock != '0) && (32'(stock) <= 32'(lobm_pkg::STOCK_COUNT));
	assign issue       = cmd.scan_run && !cnt_q[SW];
	assign rd_entry    = lobm_pkg::entry_t'(rdata);
	assign cur_valid   = valid_q[slot_s1];
	assign sidx        = lobm_pkg::SIDX_W'(stock_q - 3'd1);
	assign low_cur     = low_q[sidx];
	assign gain_new    = best_q.price - low_cur;
	assign fill_qty    = (best_q.qty < qty_q) ? best_q.qty : qty_q;

	always_comb begin
		qualifies = cur_valid && (rd_entry.stock == stock_q) && (rd_entry.is_sell != is_sell);
		if (is_sell) begin
			qualifies = qualifies && (rd_entry.price >= limit_q);
			better    = rd_entry.price > best_q.price;
		end else begin
			qualifies = qualifies && (rd_entry.price <= limit_q);
			better    = rd_entry.price < best_q.price;
		end
		better = !found_q || better ||
			((rd_entry.price == best_q.price) && (rd_entry.id < best_q.id));
	end

	always_comb begin
		we             = 1'b0;
		waddr          = best_slot_q;
		wentry         = best_q;
		wentry.qty     = best_q.qty - fill_qty;
		if (cmd.fill) begin
			we = 1'b1;
		end else if (cmd.rest && free_found_q) begin
			we             = 1'b1;
			waddr          = free_slot_q;
			wentry.is_sell = is_sell;
			wentry.stock   = stock_q;
			wentry.id      = id_q;
			wentry.qty     = qty_q;
			wentry.price   = limit_q;
		end
	end

	lobm_ram #(
		.WIDTH (lobm_pkg::ENTRY_W),
		.DEPTH (SLOTS)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wentry),
		.raddr (cnt_q[SW-1:0]),
		.rdata (rdata)
	);

	// Item registers and scan bookkeeping
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q     <= lobm_pkg::func_t'(func);
			id_q       <= order_id;
			stock_q    <= stock;
			qty_q      <= quantity;
			limit_q    <= limit_price;
			stock_ok_q <= in_stock_ok;
		end else if (cmd.fill) begin
			qty_q <= qty_q - fill_qty;
		end
		slot_s1 <= cnt_q[SW-1:0];
		if (cmd.scan_start) begin
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else if (rd_s1) begin
			if (qualifies && better) begin
				found_q     <= 1'b1;
				best_slot_q <= slot_s1;
				best_q      <= rd_entry;
			end
			if (!cur_valid && !free_found_q) begin
				free_found_q <= 1'b1;
				free_slot_q  <= slot_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			cnt_q   <= '0;
			rd_s1   <= 1'b0;
			full_q  <= 1'b0;
			for (int s = 0; s < lobm_pkg::STOCK_COUNT; s++) begin
				low_q[s]  <= '1;
				gain_q[s] <= '0;
			end
		end else begin
			rd_s1 <= issue;
			if (cmd.scan_start) begin
				cnt_q <= '0;
			end else if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.load) begin
				full_q <= 1'b0;
			end
			// Cancel drops every resting order with a matching number
			if (rd_s1 && (func_q == lobm_pkg::FUNC_CANCEL) && cur_valid &&
				(rd_entry.id == id_q)) begin
				valid_q[slot_s1] <= 1'b0;
			end
			if (cmd.fill) begin
				if (best_q.qty == fill_qty) begin
					valid_q[best_slot_q] <= 1'b0;
				end
				if ((best_q.price > low_cur) && (gain_new > gain_q[sidx])) begin
					gain_q[sidx] <= gain_new;
				end
				if (best_q.price < low_cur) begin
					low_q[sidx] <= best_q.price;
				end
			end
			if (cmd.rest) begin
				if (free_found_q) begin
					valid_q[free_slot_q] <= 1'b1;
				end else begin
					full_q <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		case (func_q)
			lobm_pkg::FUNC_BUY, lobm_pkg::FUNC_SELL: value = lobm_pkg::VALUE_W'(qty_q);
			lobm_pkg::FUNC_QUERY: value = stock_ok_q ? gain_q[sidx] : '0;
			default: value = '0;
		endcase
	end

	assign table_full = full_q;

	assign sts.need_scan = (func == lobm_pkg::FUNC_CANCEL) ||
		(((func == lobm_pkg::FUNC_BUY) || (func == lobm_pkg::FUNC_SELL)) &&
		in_stock_ok && (quantity != '0));
	assign sts.is_cancel = (func_q == lobm_pkg::FUNC_CANCEL);
	assign sts.scan_done = rd_s1 && (slot_s1 == SW'(SLOTS - 1));
	assign sts.found     = found_q;
	assign sts.fill_ends = (fill_qty == qty_q);

endmodule

[rtl/limit_order_book_matcher_top.sv]
// Work per item: a query or an order skipped for a bad stock or zero quantity goes straight
// to the finish, a cancel takes one full-table pass, and a buy or sell takes one pass per fill
// plus one when no match is left; the strobe comes in the cycle before the next accept.
// Each pass scans the full table through the RAM's single read port; one item at a time.
// The strobe lasts one cycle and cannot be stalled. Reset clears all valid bits at once,
// trade prices to all ones and gains to zero; an item is taken in the first cycle after it.
// ----------------------------------------------------------------------------
// limit_order_book_matcher_top
// Per-stock limit order book with price priority matching, ties going to the lower order id.
// ----------------------------------------------------------------------------
module limit_order_book_matcher_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    func,
	input  logic [lobm_pkg::ID_W-1:0]     order_id,
	input  logic [lobm_pkg::STOCK_W-1:0]  stock,
	input  logic [lobm_pkg::QTY_W-1:0]    quantity,
	input  logic [lobm_pkg::PRICE_W-1:0]  limit_price,
	output logic                          result_valid,
	output logic [lobm_pkg::VALUE_W-1:0]  value,
	output logic                          table_full
);

	lobm_pkg::cmd_t cmd;
	lobm_pkg::sts_t sts;
	logic           ctrl_start;

	assign ctrl_start = start && !busy;

	lobm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (ctrl_start),
		.sts          (sts),
		.cmd          (cmd),
		.busy         (busy),
		.result_valid (result_valid)
	);

	lobm_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.func        (func),
		.order_id    (order_id),
		.stock       (stock),
		.quantity    (quantity),
		.limit_price (limit_price),
		.value       (value),
		.table_full  (table_full)
	);

`ifndef SYNTHESIS
	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	a_full_has_rest: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && table_full) |-> (value != '0))
		else $error("table full reported with no remainder");
`endif

endmodule

[sim/tb_limit_order_book_matcher_top.sv]
// ----------------------------------------------------------------------------
// tb_limit_order_book_matcher_top
// Self-checking bench for the limit order book matcher. A queue-fed driver
// issues buy, sell, cancel and profit query items; a monitor predicts each
// accepted item against a behavioral order book with price priority and lower
// id first on a tie, and checks every result strobe field by field.
// ----------------------------------------------------------------------------
module tb_limit_order_book_matcher_top;

	localparam int CYCLE_LIMIT  = 8000000;
	localparam int TAIL_ITEMS   = 100;
	localparam int RANDOM_ITEMS = 570;

	typedef struct {
		lobm_pkg::func_t              fn;
		logic [lobm_pkg::ID_W-1:0]    id;
		logic [lobm_pkg::STOCK_W-1:0] stk;
		logic [lobm_pkg::QTY_W-1:0]   qty;
		logic [lobm_pkg::PRICE_W-1:0] px;
		bit                           drain;
	} order_item_t;

	typedef struct {
		logic [lobm_pkg::VALUE_W-1:0] value;
		logic                         full;
	} outcome_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	logic                          busy;
	logic [1:0]                    func = '0;
	logic [lobm_pkg::ID_W-1:0]     order_id = '0;
	logic [lobm_pkg::STOCK_W-1:0]  stock = '0;
	logic [lobm_pkg::QTY_W-1:0]    quantity = '0;
	logic [lobm_pkg::PRICE_W-1:0]  limit_price = '0;
	logic                          result_valid;
	logic [lobm_pkg::VALUE_W-1:0]  value;
	logic                          table_full;

	order_item_t pending_orders[$];
	outcome_t    expected_outcomes[$];
	bit          item_taken = 1'b0;
	int          gap_left = 0;
	int          errors = 0;
	int          cycles = 0;
	int          items_done = 0;
	int          fills_seen = 0;
	int          full_seen = 0;

	// shadow order book
	bit                           bk_valid[lobm_pkg::ORDER_SLOTS];
	bit                           bk_sell[lobm_pkg::ORDER_SLOTS];
	logic [lobm_pkg::STOCK_W-1:0] bk_stock[lobm_pkg::ORDER_SLOTS];
	logic [lobm_pkg::ID_W-1:0]    bk_id[lobm_pkg::ORDER_SLOTS];
	logic [lobm_pkg::QTY_W-1:0]   bk_qty[lobm_pkg::ORDER_SLOTS];
	logic [lobm_pkg::PRICE_W-1:0] bk_price[lobm_pkg::ORDER_SLOTS];
	logic [lobm_pkg::PRICE_W-1:0] lowest_px[lobm_pkg::STOCK_COUNT];
	logic [lobm_pkg::VALUE_W-1:0] best_gain[lobm_pkg::STOCK_COUNT];

	limit_order_book_matcher_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.order_id(order_id), .stock(stock), .quantity(quantity),
		.limit_price(limit_price), .result_valid(result_valid), .value(value),
		.table_full(table_full)
	);

	always #10 clk = ~clk;

	function automatic int best_match(bit sell, logic [lobm_pkg::STOCK_W-1:0] s,
			logic [lobm_pkg::PRICE_W-1:0] lim);
		int best;
		best = -1;
		for (int i = 0; i < lobm_pkg::ORDER_SLOTS; i++) begin
			if (!bk_valid[i] || bk_stock[i] != s || bk_sell[i] == sell)
				continue;
			if (sell ? (bk_price[i] < lim) : (bk_price[i] > lim))
				continue;
			if (best < 0)
				best = i;
			else if ((sell ? (bk_price[i] > bk_price[best]) : (bk_price[i] < bk_price[best]))
					|| (bk_price[i] == bk_price[best] && bk_id[i] < bk_id[best]))
				best = i;
		end
		return best;
	endfunction

	task automatic trade_at(int si, logic [lobm_pkg::PRICE_W-1:0] p);
		if (p > lowest_px[si] && (p - lowest_px[si]) > best_gain[si])
			best_gain[si] = p - lowest_px[si];
		if (p < lowest_px[si])
			lowest_px[si] = p;
		fills_seen++;
	endtask

	task automatic match_order(lobm_pkg::func_t fn, logic [lobm_pkg::ID_W-1:0] id,
			logic [lobm_pkg::STOCK_W-1:0] s, logic [lobm_pkg::QTY_W-1:0] q,
			logic [lobm_pkg::PRICE_W-1:0] lim, output outcome_t r);
		bit sell;
		bit ok;
		int b;
		int slot;
		logic [lobm_pkg::QTY_W-1:0] take;
		sell = (fn == lobm_pkg::FUNC_SELL);
		ok = (s >= 1 && s <= lobm_pkg::STOCK_COUNT);
		r.value = '0;
		r.full = 1'b0;
		case (fn)
			lobm_pkg::FUNC_BUY, lobm_pkg::FUNC_SELL: begin
				if (ok) begin
					while (q > 0) begin
						b = best_match(sell, s, lim);
						if (b < 0)
							break;
						take = (bk_qty[b] < q) ? bk_qty[b] : q;
						trade_at(s - 1, bk_price[b]);
						q -= take;
						bk_qty[b] -= take;
						if (bk_qty[b] == 0)
							bk_valid[b] = 1'b0;
					end
					if (q > 0) begin
						slot = -1;
						for (int i = 0; i < lobm_pkg::ORDER_SLOTS; i++)
							if (!bk_valid[i]) begin
								slot = i;
								break;
							end
						if (slot < 0) begin
							r.full = 1'b1;
						end else begin
							bk_valid[slot] = 1'b1;
							bk_sell[slot] = sell;
							bk_stock[slot] = s;
							bk_id[slot] = id;
							bk_qty[slot] = q;
							bk_price[slot] = lim;
						end
					end
				end
				r.value = lobm_pkg::VALUE_W'(q);
			end
			lobm_pkg::FUNC_CANCEL: begin
				for (int i = 0; i < lobm_pkg::ORDER_SLOTS; i++)
					if (bk_valid[i] && bk_id[i] == id)
						bk_valid[i] = 1'b0;
			end
			default: begin
				if (ok)
					r.value = best_gain[s - 1];
			end
		endcase
	endtask

	function automatic order_item_t mk(lobm_pkg::func_t fn, int id, int s, int q, int px);
		order_item_t it;
		it.fn = fn;
		it.id = lobm_pkg::ID_W'(id);
		it.stk = lobm_pkg::STOCK_W'(s);
		it.qty = lobm_pkg::QTY_W'(q);
		it.px = lobm_pkg::PRICE_W'(px);
		it.drain = 1'b0;
		return it;
	endfunction

	function automatic order_item_t drain_mark();
		order_item_t it;
		it = mk(lobm_pkg::FUNC_QUERY, 0, 0, 0, 0);
		it.drain = 1'b1;
		return it;
	endfunction

	function automatic order_item_t random_order();
		order_item_t it;
		int r;
		int f;
		f = $urandom_range(0, 99);
		it.fn = (f < 40) ? lobm_pkg::FUNC_BUY : (f < 80) ? lobm_pkg::FUNC_SELL :
			(f < 90) ? lobm_pkg::FUNC_CANCEL : lobm_pkg::FUNC_QUERY;
		it.drain = 1'b0;
		r = $urandom_range(0, 99);
		// mostly a narrow book so orders cross; now and then raw fields
		if (r < 8) begin
			it.id = lobm_pkg::ID_W'($urandom);
			it.stk = lobm_pkg::STOCK_W'($urandom);
			it.qty = lobm_pkg::QTY_W'($urandom);
			it.px = lobm_pkg::PRICE_W'($urandom);
		end else begin
			it.id = lobm_pkg::ID_W'($urandom_range(0, 63));
			it.stk = lobm_pkg::STOCK_W'((r < 12) ? $urandom_range(0, 7) :
				$urandom_range(1, lobm_pkg::STOCK_COUNT));
			it.qty = lobm_pkg::QTY_W'((r < 16) ? $urandom_range(0, 65535) :
				$urandom_range(1, 60));
			it.px = lobm_pkg::PRICE_W'((r < 16) ? $urandom_range(0, 1048575) :
				$urandom_range(990, 1010));
		end
		return it;
	endfunction

	// driver: change inputs on the falling edge
	always @(negedge clk) begin
		if (arst_n && !(start && !item_taken)) begin
			if (pending_orders.size() > 0 && pending_orders[0].drain) begin
				start <= 1'b0;
				if (expected_outcomes.size() == 0 && !busy)
					void'(pending_orders.pop_front());
			end else if (gap_left > 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_orders.size() > 0) begin
				order_item_t it;
				it = pending_orders.pop_front();
				start <= 1'b1;
				func <= it.fn;
				order_id <= it.id;
				stock <= it.stk;
				quantity <= it.qty;
				limit_price <= it.px;
				if (pending_orders.size() > TAIL_ITEMS && $urandom_range(0, 3) == 0)
					gap_left <= $urandom_range(1, 7);
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: predict on accept, check on strobe
	always @(posedge clk) begin
		outcome_t got;
		outcome_t exp_r;
		item_taken <= arst_n && start && !busy;
		if (arst_n && start && !busy) begin
			match_order(lobm_pkg::func_t'(func), order_id, stock, quantity, limit_price,
				exp_r);
			expected_outcomes.push_back(exp_r);
			items_done++;
			if (exp_r.full)
				full_seen++;
		end
		if (arst_n && result_valid) begin
			got.value = value;
			got.full = table_full;
			if (expected_outcomes.size() == 0) begin
				$display("%0t: unexpected result value=%0d table_full=%0b",
					$realtime, got.value, got.full);
				errors++;
			end else begin
				exp_r = expected_outcomes.pop_front();
				if (got.value !== exp_r.value) begin
					$display("%0t: value expected %0d actual %0d",
						$realtime, exp_r.value, got.value);
					errors++;
				end
				if (got.full !== exp_r.full) begin
					$display("%0t: table_full expected %0b actual %0b",
						$realtime, exp_r.full, got.full);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < lobm_pkg::ORDER_SLOTS; i++)
			bk_valid[i] = 1'b0;
		for (int s = 0; s < lobm_pkg::STOCK_COUNT; s++) begin
			lowest_px[s] = '1;
			best_gain[s] = '0;
		end

		// directed: priority, partial fills, extremes, odd stocks
		pending_orders.push_back(mk(lobm_pkg::FUNC_QUERY, 0, 1, 0, 0));
		pending_orders.push_back(mk(lobm_pkg::FUNC_SELL, 10, 1, 100, 50));
		pending_orders.push_back(mk(lobm_pkg::FUNC_SELL, 5, 1, 30, 50));
		pending_orders.push_back(mk(lobm_pkg::FUNC_SELL, 7, 1, 20, 40));
		pending_orders.push_back(mk(lobm_pkg::FUNC_BUY, 20, 1, 140, 50));
		pending_orders.push_back(mk(lobm_pkg::FUNC_QUERY, 0, 1, 0, 0));
		pending_orders.push_back(mk(lobm_pkg::FUNC_BUY, 21, 1, 5, 49));
		pending_orders.push_back(mk(lobm_pkg::FUNC_SELL, 22, 1, 8, 45));
		pending_orders.push_back(mk(lobm_pkg::FUNC_BUY, 'hFFFFF, 5, 'hFFFF, 'hFFFFF));
		pending_orders.push_back(mk(lobm_pkg::FUNC_SELL, 0, 5, 1, 1));
		pending_orders.push_back(mk(lobm_pkg::FUNC_QUERY, 0, 5, 0, 0));
		pending_orders.push_back(mk(lobm_pkg::FUNC_CANCEL, 'hFFFFF, 7, 0, 0));
		pending_orders.push_back(mk(lobm_pkg::FUNC_CANCEL, 999, 1, 0, 0));
		pending_orders.push_back(mk(lobm_pkg::FUNC_BUY, 30, 0, 12, 100));
		pending_orders.push_back(mk(lobm_pkg::FUNC_SELL, 31, 6, 12, 100));
		pending_orders.push_back(mk(lobm_pkg::FUNC_BUY, 32, 7, 12, 100));
		pending_orders.push_back(mk(lobm_pkg::FUNC_BUY, 33, 2, 0, 100));
		pending_orders.push_back(mk(lobm_pkg::FUNC_SELL, 34, 2, 3, 0));
		pending_orders.push_back(mk(lobm_pkg::FUNC_QUERY, 0, 0, 0, 0));
		pending_orders.push_back(mk(lobm_pkg::FUNC_QUERY, 0, 7, 0, 0));
		pending_orders.push_back(drain_mark());

		// fill the table, overflow it, then free it with one cancel
		for (int i = 0; i < lobm_pkg::ORDER_SLOTS + 4; i++)
			pending_orders.push_back(mk(lobm_pkg::FUNC_BUY, 1234, 3,
				$urandom_range(1, 9), 1));
		pending_orders.push_back(mk(lobm_pkg::FUNC_CANCEL, 1234, 3, 0, 0));
		pending_orders.push_back(drain_mark());

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 2)
				pending_orders.push_back(drain_mark());
			pending_orders.push_back(random_order());
		end

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		wait (pending_orders.size() == 0 && !start && expected_outcomes.size() == 0);
		repeat (20) @(posedge clk);
		$display("covered %0d items: %0d fills, %0d drops on a full book",
			items_done, fills_seen, full_seen);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
